// ===== design/mpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// shared codes, command type and widths of the multilevel priority ready queue
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int DEF_LEVELS      = 4;
  localparam int DEF_LEVEL_DEPTH = 16;
  localparam int LV_W            = 5;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_REM = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ILLEGAL   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_INTERRUPT = 3'd5;

  localparam logic [2:0] REG_LEVEL_COUNT_RESET = 3'd4;

  typedef struct packed {
    logic [1:0]      mode;
    logic [7:0]      id;
    logic [2:0]      prio;
    logic            illegal;
    logic            intr;
    logic [LV_W-1:0] lv;
  } cmd_t;

endpackage

// ===== design/mpq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_front
// accepts commands, classifies priority and mode, holds them in a two-entry queue
// ----------------------------------------------------------------------------
module mpq_front #(
  parameter int LEVELS = mpq_pkg::DEF_LEVELS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    mode,
  input  logic [7:0]    proc_id,
  input  logic [2:0]    priority_req,
  input  logic          is_interrupt_process,
  input  logic [2:0]    level_count,
  output logic          cmd_valid,
  output mpq_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import mpq_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  cmd_t       cls;
  logic [LV_W-1:0] lv;
  logic       push;

  always_comb begin
    if ({2'b00, level_count} > LV_W'(LEVELS)) begin
      lv = LV_W'(LEVELS);
    end else begin
      lv = {2'b00, level_count};
    end
    cls.mode    = mode;
    cls.id      = proc_id;
    cls.prio    = priority_req;
    cls.intr    = is_interrupt_process;
    cls.lv      = lv;
    cls.illegal = (mode == 2'd3) ||
                  (((mode == MODE_ENQ) || (mode == MODE_REM)) && ({2'b00, priority_req} >= lv));
  end

  assign busy      = (cnt == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (cmd_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== design/mpq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_back
// executes queued commands against the per-level ring buffers in one memory
// ----------------------------------------------------------------------------
module mpq_back #(
  parameter int LEVELS      = mpq_pkg::DEF_LEVELS,
  parameter int LEVEL_DEPTH = mpq_pkg::DEF_LEVEL_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  mpq_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          done,
  output logic [2:0]    status,
  output logic [7:0]    out_id,
  output logic [1:0]    out_level
);
  import mpq_pkg::*;

  localparam int MEM_DEPTH = LEVELS * LEVEL_DEPTH;
  localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HW = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CW = $clog2(LEVEL_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DEQ, S_SRCH, S_SHIFT} state_t;

  state_t        state;
  logic [7:0]    mem [MEM_DEPTH];
  logic [7:0]    rdata;
  logic [HW-1:0] heads  [LEVELS];
  logic [CW-1:0] counts [LEVELS];
  logic [LW-1:0] cur_lvl;
  logic [7:0]    cur_id;
  logic [CW-1:0] pos;

  logic          any_ready;
  logic [LW-1:0] first_lvl;
  logic [LW-1:0] cmd_lvl;
  logic [LW-1:0] rd_lvl;
  logic [CW:0]   rd_pos;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          enq_ok;

  function automatic logic [AW-1:0] slot(input logic [LW-1:0] l, input logic [CW:0] p);
    logic [CW+1:0] s;
    s = (CW+2)'(heads[l]) + (CW+2)'(p);
    if (s >= (CW+2)'(LEVEL_DEPTH)) begin
      s = s - (CW+2)'(LEVEL_DEPTH);
    end
    return AW'(l * LEVEL_DEPTH + s);
  endfunction

  always_comb begin
    any_ready = 1'b0;
    first_lvl = '0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if ((LV_W'(l) < cmd.lv) && (counts[l] != '0)) begin
        any_ready = 1'b1;
        first_lvl = LW'(l);
      end
    end
  end

  always_comb begin
    cmd_lvl = LW'(cmd.prio);
    cmd_pop = (state == S_IDLE) && cmd_valid;
    enq_ok  = (cmd.mode == MODE_ENQ) && !cmd.illegal && !cmd.intr &&
              (counts[cmd_lvl] < CW'(LEVEL_DEPTH));
    unique case (state)
      S_IDLE:  begin
        rd_lvl = (cmd.mode == MODE_DEQ) ? first_lvl : cmd_lvl;
        rd_pos = '0;
      end
      S_SRCH:  begin
        rd_lvl = cur_lvl;
        rd_pos = (CW+1)'(pos) + (CW+1)'(1);
      end
      S_SHIFT: begin
        rd_lvl = cur_lvl;
        rd_pos = (CW+1)'(pos) + (CW+1)'(2);
      end
      default: begin
        rd_lvl = cur_lvl;
        rd_pos = '0;
      end
    endcase
    rd_addr = slot(rd_lvl, rd_pos);
    if (state == S_SHIFT) begin
      wr_en   = 1'b1;
      wr_addr = slot(cur_lvl, (CW+1)'(pos));
      wr_data = rdata;
    end else begin
      wr_en   = cmd_pop && enq_ok;
      wr_addr = slot(cmd_lvl, (CW+1)'(counts[cmd_lvl]));
      wr_data = cmd.id;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      status    <= ST_OK;
      out_id    <= '0;
      out_level <= '0;
      cur_lvl   <= '0;
      cur_id    <= '0;
      pos       <= '0;
      for (int l = 0; l < LEVELS; l++) begin
        heads[l]  <= '0;
        counts[l] <= '0;
      end
    end else begin
      done      <= 1'b0;
      out_id    <= '0;
      out_level <= '0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur_id <= cmd.id;
            unique case (cmd.mode)
              MODE_ENQ: begin
                done <= 1'b1;
                if (cmd.illegal) begin
                  status <= ST_ILLEGAL;
                end else if (cmd.intr) begin
                  status <= ST_INTERRUPT;
                end else if (!enq_ok) begin
                  status <= ST_FULL;
                end else begin
                  status          <= ST_OK;
                  out_id          <= cmd.id;
                  out_level       <= 2'(cmd.prio);
                  counts[cmd_lvl] <= counts[cmd_lvl] + CW'(1);
                end
              end
              MODE_DEQ: begin
                if (!any_ready) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  cur_lvl <= first_lvl;
                  state   <= S_DEQ;
                end
              end
              MODE_REM: begin
                if (cmd.illegal) begin
                  done   <= 1'b1;
                  status <= ST_ILLEGAL;
                end else if (counts[cmd_lvl] == '0) begin
                  done   <= 1'b1;
                  status <= ST_NOTFOUND;
                end else begin
                  cur_lvl <= cmd_lvl;
                  pos     <= '0;
                  state   <= S_SRCH;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_ILLEGAL;
              end
            endcase
          end
        end
        S_DEQ: begin
          done      <= 1'b1;
          status    <= ST_OK;
          out_id    <= rdata;
          out_level <= 2'(cur_lvl);
          if (heads[cur_lvl] == HW'(LEVEL_DEPTH - 1)) begin
            heads[cur_lvl] <= '0;
          end else begin
            heads[cur_lvl] <= heads[cur_lvl] + HW'(1);
          end
          counts[cur_lvl] <= counts[cur_lvl] - CW'(1);
          state <= S_IDLE;
        end
        S_SRCH: begin
          if (rdata == cur_id) begin
            if ((CW+1)'(pos) + (CW+1)'(1) < (CW+1)'(counts[cur_lvl])) begin
              state <= S_SHIFT;
            end else begin
              done            <= 1'b1;
              status          <= ST_OK;
              out_id          <= cur_id;
              out_level       <= 2'(cur_lvl);
              counts[cur_lvl] <= counts[cur_lvl] - CW'(1);
              state           <= S_IDLE;
            end
          end else if ((CW+1)'(pos) + (CW+1)'(1) < (CW+1)'(counts[cur_lvl])) begin
            pos <= pos + CW'(1);
          end else begin
            done   <= 1'b1;
            status <= ST_NOTFOUND;
            state  <= S_IDLE;
          end
        end
        S_SHIFT: begin
          pos <= pos + CW'(1);
          if ((CW+1)'(pos) + (CW+1)'(2) >= (CW+1)'(counts[cur_lvl])) begin
            done            <= 1'b1;
            status          <= ST_OK;
            out_id          <= cur_id;
            out_level       <= 2'(cur_lvl);
            counts[cur_lvl] <= counts[cur_lvl] - CW'(1);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (state == S_IDLE))
    else $error("command taken while back end busy");
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((out_id == '0) && (out_level == '0)))
    else $error("nonzero id on failed command");
  a_deq_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |=> done)
    else $error("dequeue did not complete");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    counts[cur_lvl] <= CW'(LEVEL_DEPTH))
    else $error("level count beyond depth");

endmodule

// ===== design/multilevel_priority_ready_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_ready_queue
// ready queue of process ids with one fifo per priority level
// ----------------------------------------------------------------------------
// Commands are taken while busy is low into a two-entry command queue. An
// enqueue is registered in the command queue and then completes in the back
// end's idle state; a dequeue reads its entry in S_DEQ before it completes,
// and a remove walks the level in S_SRCH and S_SHIFT one entry a cycle
// through the single registered read port of the entry memory. A command
// taken while the back end is busy first waits in the queue for the commands
// ahead of it. Each result is shown on status, out_id and out_level for one
// cycle with done high and must be taken then.
module multilevel_priority_ready_queue #(
  parameter int LEVELS      = mpq_pkg::DEF_LEVELS,
  parameter int LEVEL_DEPTH = mpq_pkg::DEF_LEVEL_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  proc_id,
  input  logic [2:0]  priority_req,
  input  logic        is_interrupt_process,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  out_id,
  output logic [1:0]  out_level,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mpq_pkg::*;

  logic [2:0] level_count;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {29'd0, level_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= REG_LEVEL_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == 1'b0)) begin
      level_count <= pwdata[2:0];
    end
  end

  mpq_front #(.LEVELS(LEVELS)) u_front (
    .clk                  (clk),
    .rst                  (rst),
    .start                (start),
    .busy                 (busy),
    .mode                 (mode),
    .proc_id              (proc_id),
    .priority_req         (priority_req),
    .is_interrupt_process (is_interrupt_process),
    .level_count          (level_count),
    .cmd_valid            (cmd_valid),
    .cmd                  (cmd),
    .cmd_pop              (cmd_pop)
  );

  mpq_back #(.LEVELS(LEVELS), .LEVEL_DEPTH(LEVEL_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .done      (done),
    .status    (status),
    .out_id    (out_id),
    .out_level (out_level)
  );

endmodule
